// ===== sv/shd_pkg.sv =====
// shared constants and types for the spot detection high-pass filter
package shd_pkg;

  localparam int unsigned MAX_HALF   = 32;
  localparam int unsigned LINE_DEPTH = 2 * MAX_HALF;
  localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
  localparam int unsigned POS_W      = $clog2(LINE_DEPTH + 1);
  localparam int unsigned HALF_W     = 6;
  localparam int unsigned HCNT_W     = $clog2(MAX_HALF + 1);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VALUE_W    = 15;
  localparam int unsigned SUM_W      = SAMPLE_W + 3;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // register map
  localparam logic [PADDR_W-1:0] REG_HALF_WIDTH = 3'd0;
  localparam logic [HALF_W-1:0]  HALF_RESET     = 6'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [VALUE_W-1:0]         value_t;

  // taps handed from the delay line to the difference stage
  typedef struct packed {
    logic    enable;
    sample_t mid;
    sample_t far;
    sample_t cur;
  } shd_taps_t;

endpackage

// ===== sv/shd_cell.sv =====
// one cell of the sample delay line
module shd_cell
  import shd_pkg::*;
(
  input  logic    clk_i,
  input  logic    shift_i,
  input  sample_t d_i,
  output sample_t q_o
);

  sample_t data_q;

  // take the neighbour's sample, or the input sample at the head, on every accepted word
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

// ===== sv/shd_diff.sv =====
// rectified, saturated spaced second difference
module shd_diff
  import shd_pkg::*;
(
  input  shd_taps_t taps_i,
  output value_t    value_o
);

  logic signed [SUM_W-1:0] sum;

  // 2*mid - far - cur at full width
  assign sum = (SUM_W'(taps_i.mid) <<< 1) - SUM_W'(taps_i.far) - SUM_W'(taps_i.cur);

  // zero when disabled; clip to zero below, to full scale above
  always_comb begin
    if (!taps_i.enable || sum <= 0) begin
      value_o = '0;
    end else if (sum > SUM_W'(2 ** VALUE_W - 1)) begin
      value_o = '1;
    end else begin
      value_o = sum[VALUE_W-1:0];
    end
  end

endmodule

// ===== sv/spot_detection_highpass_1d.sv =====
// spot detection high-pass filter: delay line of cells, difference stage, output register
// output: an accepted sample's word is written to the output register and shows in the next cycle
// throughput: one sample per cycle while the output is not stalled; a final sample adds h
//   trailing zero words (a vector of i+1 samples with i below h gets i+1 zeros, i of them
//   after the final word), during which no sample is accepted
// reset: asynchronous, active low; clears position count, output valid and burst count,
//   half width returns to 1; the delay line cells are not reset
module spot_detection_highpass_1d
  import shd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // sample stream in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [15:0] sample
  input  logic               s_axis_tlast,   // is_final
  // filtered stream out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // [14:0] value, [15] zero
  output logic               m_axis_tlast    // end_of_vector
);

  logic [HALF_W-1:0] half_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [HCNT_W-1:0] zcnt_q, zcnt_d;
  logic              ovalid_q, ovalid_d;
  value_t            oval_q, oval_d;
  logic              oeov_q, oeov_d;

  logic              accept, slot_free;
  logic [HCNT_W-1:0] h_eff;
  logic [IDX_W-1:0]  mid_idx, far_idx;
  logic [POS_W-1:0]  h_pos, h2_pos;
  sample_t           cur;
  sample_t           taps [LINE_DEPTH];
  shd_taps_t         dtaps;
  value_t            dval;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_HALF_WIDTH)) begin
      half_q <= pwdata[HALF_W-1:0];
    end
  end
  assign prdata = (paddr == REG_HALF_WIDTH) ? PDATA_W'(half_q) : '0;

  // effective half width, clipped to half the line length
  assign h_eff   = (half_q > HALF_W'(MAX_HALF)) ? HCNT_W'(MAX_HALF) : half_q[HCNT_W-1:0];
  assign h_pos   = POS_W'(h_eff);
  assign h2_pos  = POS_W'(h_eff) << 1;
  assign mid_idx = IDX_W'(h_pos - POS_W'(1));
  assign far_idx = IDX_W'(h2_pos - POS_W'(1));

  // handshake
  assign slot_free     = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (zcnt_q == '0) && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cur           = sample_t'(s_axis_tdata);

  // delay line: row of cells, newest at index zero
  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_line
    if (g == 0) begin : g_head
      shd_cell u_cell (.clk_i(clk_i), .shift_i(accept), .d_i(cur), .q_o(taps[g]));
    end else begin : g_body
      shd_cell u_cell (.clk_i(clk_i), .shift_i(accept), .d_i(taps[g-1]), .q_o(taps[g]));
    end
  end

  // difference stage
  assign dtaps.enable = (h_eff != '0) && (pos_q >= h2_pos);
  assign dtaps.mid    = taps[mid_idx];
  assign dtaps.far    = taps[far_idx];
  assign dtaps.cur    = cur;

  shd_diff u_diff (.taps_i(dtaps), .value_o(dval));

  // output register, trailing zero burst and position count
  always_comb begin
    pos_d    = pos_q;
    zcnt_d   = zcnt_q;
    oval_d   = oval_q;
    oeov_d   = oeov_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    if (accept) begin
      if (pos_q >= h_pos) begin
        ovalid_d = 1'b1;
        oval_d   = dval;
        oeov_d   = s_axis_tlast && (h_eff == '0);
        zcnt_d   = s_axis_tlast ? h_eff : '0;
      end else if (s_axis_tlast) begin
        // short vector: i+1 zeros, i below h so it fits the counter
        ovalid_d = 1'b1;
        oval_d   = '0;
        oeov_d   = (pos_q == '0);
        zcnt_d   = HCNT_W'(pos_q);
      end
      if (s_axis_tlast) begin
        pos_d = '0;
      end else if (pos_q < POS_W'(LINE_DEPTH)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end else if ((zcnt_q != '0) && slot_free) begin
      ovalid_d = 1'b1;
      oval_d   = '0;
      oeov_d   = (zcnt_q == HCNT_W'(1));
      zcnt_d   = zcnt_q - HCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      zcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      zcnt_q   <= zcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oval_q <= oval_d;
    oeov_q <= oeov_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, oval_q};
  assign m_axis_tlast  = oeov_q;

endmodule
